FILE: src/chd_pkg.sv
// Shared types and constants for the chunked body decoder.
package chd_pkg;

   localparam int SIZE_LINE_LIMIT_DEFAULT = 32;
   localparam int COUNT_WIDTH_DEFAULT     = 32;

   localparam int LIMIT_WIDTH = 26;
   localparam logic [LIMIT_WIDTH-1:0] MAX_OUTPUT_RESET = 26'd33554431;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic CSR_IDX_MAX_OUTPUT = 1'b0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_DATA       = 3'd0,
      ST_ZERO_CHUNK = 3'd1,
      ST_EARLY_END  = 3'd2,
      ST_LINE_LONG  = 3'd3,
      ST_TOO_LARGE  = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      PH_SIZE      = 5'b00001,
      PH_DATA      = 5'b00010,
      PH_SKIP      = 5'b00100,
      PH_DONE      = 5'b01000,
      PH_SIZE_ZERO = 5'b10000
   } phase_type;

   typedef enum logic [3:0] {
      SUB_WS     = 4'b0001,
      SUB_SIGN   = 4'b0010,
      SUB_DIGITS = 4'b0100,
      SUB_IGNORE = 4'b1000
   } sub_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       last_of_run;
   } result_type;

   // Up to two results produced by one input byte, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

FILE: src/chd_parse.sv
// Per-byte chunk parser: body state registers and the next-state logic.
module chd_parse
   import chd_pkg::*;
#(
   parameter int SIZE_LINE_LIMIT = SIZE_LINE_LIMIT_DEFAULT,
   parameter int COUNT_WIDTH     = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_body,
   input  logic [LIMIT_WIDTH-1:0] max_output_bytes,
   output result_pair_type        results
);

   localparam int LINE_WIDTH = $clog2(SIZE_LINE_LIMIT + 1);
   localparam logic [LINE_WIDTH-1:0] LINE_LIMIT = LINE_WIDTH'(SIZE_LINE_LIMIT);
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   phase_type               phase_ff, phase_in;
   sub_phase_type           sub_ff, sub_in;
   logic [COUNT_WIDTH-1:0]  chunk_ff, chunk_in;
   logic                    minus_ff, minus_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;
   logic [LIMIT_WIDTH-1:0]  outcnt_ff, outcnt_in;

   logic                    is_newline;
   logic                    is_space;
   logic                    is_sign;
   logic                    is_x;
   logic                    hex_ok;
   logic [3:0]              hex_val;
   logic [COUNT_WIDTH-1:0]  digit_add;
   logic [COUNT_WIDTH-1:0]  line_count_value;
   logic                    start_number;
   logic                    data_out;
   logic                    has_fin;
   status_type              fin;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (data_byte >= "0" && data_byte <= "9") begin
         hex_val = 4'(data_byte - "0");
      end else if (data_byte >= "a" && data_byte <= "f") begin
         hex_val = 4'(data_byte - "a" + 8'd10);
      end else if (data_byte >= "A" && data_byte <= "F") begin
         hex_val = 4'(data_byte - "A" + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign is_newline = (data_byte == CH_NEWLINE);
   assign is_space   = (data_byte == 8'h20) || (data_byte == 8'h09) || (data_byte == 8'h0B)
                    || (data_byte == 8'h0C) || (data_byte == 8'h0D);
   assign is_sign    = (data_byte == "+") || (data_byte == "-");
   assign is_x       = (data_byte == "x") || (data_byte == "X");

   // A digit that would push bits out of the top saturates the count.
   assign digit_add = (chunk_ff[COUNT_WIDTH-1 -: 4] != 4'd0) ? '1
                    : {chunk_ff[COUNT_WIDTH-5:0], hex_val};

   // A minus sign turns any nonzero count into the largest one.
   assign line_count_value = (minus_ff && chunk_ff != '0) ? '1 : chunk_ff;

   always_comb begin
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      chunk_in     = chunk_ff;
      minus_in     = minus_ff;
      line_in      = line_ff;
      outcnt_in    = outcnt_ff;
      start_number = 1'b0;
      data_out     = 1'b0;
      has_fin      = 1'b0;
      fin          = ST_DATA;

      unique case (phase_ff)
         PH_SIZE, PH_SIZE_ZERO: begin
            if (is_newline) begin
               if (line_ff >= LINE_LIMIT) begin
                  has_fin = 1'b1;
                  fin     = ST_LINE_LONG;
               end else if (line_count_value == '0) begin
                  has_fin = 1'b1;
                  fin     = ST_ZERO_CHUNK;
               end else begin
                  chunk_in = line_count_value;
                  phase_in = PH_DATA;
               end
            end else begin
               if (line_ff < LINE_LIMIT) begin
                  line_in = line_ff + 1'b1;
               end
               if (phase_ff == PH_SIZE_ZERO) begin
                  // The byte after a lone leading zero may be the x of a prefix.
                  phase_in = PH_SIZE;
                  if (is_x) begin
                     sub_in = SUB_DIGITS;
                  end else if (hex_ok) begin
                     chunk_in = digit_add;
                     sub_in   = SUB_DIGITS;
                  end else begin
                     sub_in = SUB_IGNORE;
                  end
               end else begin
                  case (sub_ff)
                     SUB_WS: begin
                        if (is_sign) begin
                           minus_in = (data_byte == "-");
                           sub_in   = SUB_SIGN;
                        end else if (!is_space) begin
                           start_number = 1'b1;
                        end
                     end
                     SUB_SIGN: begin
                        start_number = 1'b1;
                     end
                     SUB_DIGITS: begin
                        if (hex_ok) begin
                           chunk_in = digit_add;
                        end else begin
                           sub_in = SUB_IGNORE;
                        end
                     end
                     default: begin
                     end
                  endcase
                  if (start_number) begin
                     if (data_byte == "0") begin
                        phase_in = PH_SIZE_ZERO;
                        sub_in   = SUB_DIGITS;
                     end else if (hex_ok) begin
                        chunk_in = digit_add;
                        sub_in   = SUB_DIGITS;
                     end else begin
                        sub_in = SUB_IGNORE;
                     end
                  end
               end
            end
         end
         PH_DATA: begin
            if (outcnt_ff >= max_output_bytes) begin
               has_fin = 1'b1;
               fin     = ST_TOO_LARGE;
            end else begin
               data_out  = 1'b1;
               outcnt_in = outcnt_ff + 1'b1;
               chunk_in  = chunk_ff - 1'b1;
               if (chunk_ff == COUNT_WIDTH'(1)) begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (is_newline) begin
               phase_in = PH_SIZE;
               sub_in   = SUB_WS;
               chunk_in = '0;
               minus_in = 1'b0;
               line_in  = '0;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (has_fin) begin
         phase_in = PH_DONE;
      end else if (end_of_body && phase_in != PH_DONE) begin
         has_fin = 1'b1;
         fin     = ST_EARLY_END;
      end

      if (end_of_body) begin
         phase_in  = PH_SIZE;
         sub_in    = SUB_WS;
         chunk_in  = '0;
         minus_in  = 1'b0;
         line_in   = '0;
         outcnt_in = '0;
      end
   end

   always_comb begin
      results.count              = {1'b0, data_out} + {1'b0, has_fin};
      results.second.out_byte    = 8'd0;
      results.second.status      = fin;
      results.second.last_of_run = 1'b1;
      if (data_out) begin
         results.first.out_byte    = data_byte;
         results.first.status      = ST_DATA;
         results.first.last_of_run = !has_fin;
      end else begin
         results.first = results.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIZE;
         sub_ff    <= SUB_WS;
         chunk_ff  <= '0;
         minus_ff  <= 1'b0;
         line_ff   <= '0;
         outcnt_ff <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         sub_ff    <= sub_in;
         chunk_ff  <= chunk_in;
         minus_ff  <= minus_in;
         line_ff   <= line_in;
         outcnt_ff <= outcnt_in;
      end
   end

endmodule

FILE: src/chd_rsp_queue.sv
// Result queue that takes up to two results per cycle and delivers one whenever the consumer is ready.
module chd_rsp_queue
   import chd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_pair_type push_data,
   output logic            has_room,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output result_type      rsp_data
);

   result_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ff, wr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ff, rd_in;
   logic [QUEUE_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [1:0]                  push_n;
   logic                        pop;

   assign push_n    = push ? push_data.count : 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = mem_ff[rd_ff];
   // Room for the two results a single byte can cause.
   assign has_room  = (cnt_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));

   assign wr_in  = wr_ff + QUEUE_PTR_WIDTH'(push_n);
   assign rd_in  = rd_ff + QUEUE_PTR_WIDTH'(pop);
   assign cnt_in = cnt_ff + QUEUE_CNT_WIDTH'(push_n) - QUEUE_CNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= push_data.first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ff + 1'b1] <= push_data.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: src/http_chunked_body_decoder.sv
// The results of an accepted byte are written into the result queue at acceptance and offered after earlier results.
// One byte per cycle while ready is high; the parser state updates in the accepting cycle.
// A byte that causes two results delivers them one at a time; a four-entry result queue
// absorbs them and ready drops only when fewer than two entries are free.
// Reset (synchronous) clears the body state and the queue, and sets the output limit
// register to 33554431.
module http_chunked_body_decoder
   import chd_pkg::*;
#(
   parameter int SIZE_LINE_LIMIT = SIZE_LINE_LIMIT_DEFAULT,
   parameter int COUNT_WIDTH     = COUNT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_end_of_body,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic [2:0]                rsp_status,
   output logic                      rsp_last_of_run,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [LIMIT_WIDTH-1:0] max_out_ff;
   logic                   csr_index;
   logic                   fire;
   result_pair_type        results;
   result_type             rsp_data;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1];
   assign prdata    = (csr_index == CSR_IDX_MAX_OUTPUT)
                    ? CSR_DATA_WIDTH'(max_out_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff <= MAX_OUTPUT_RESET;
      end else if (psel && penable && pwrite && pready
                   && csr_index == CSR_IDX_MAX_OUTPUT) begin
         max_out_ff <= pwdata[LIMIT_WIDTH-1:0];
      end
   end

   assign fire = req_valid && req_ready;

   chd_parse #(
      .SIZE_LINE_LIMIT(SIZE_LINE_LIMIT),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .data_byte(req_data_byte),
      .end_of_body(req_end_of_body),
      .max_output_bytes(max_out_ff),
      .results(results)
   );

   chd_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(fire),
      .push_data(results),
      .has_room(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_status      = rsp_data.status;
   assign rsp_last_of_run = rsp_data.last_of_run;

endmodule

FILE: src/chd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
module chd_checker
   import chd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_status,
   input logic       rsp_last_of_run
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // A final status is always the last result of its byte.
   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DATA |-> rsp_last_of_run)
      else $error("final status not marked last");

   // A final status carries a zero byte.
   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DATA |-> rsp_out_byte == 8'd0)
      else $error("final status with nonzero byte");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_TOO_LARGE)
      else $error("undefined status code");

   // Reset leaves an empty queue that can take a byte.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("queue not empty after reset");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_out_byte(rsp_out_byte),
   .rsp_status(rsp_status),
   .rsp_last_of_run(rsp_last_of_run)
);

FILE: verif/tb_http_chunked_body_decoder.sv
// Self-checking testbench for http_chunked_body_decoder: random chunked bodies, limit sweeps.
module tb_http_chunked_body_decoder;
   import chd_pkg::*;

   localparam logic [7:0] LF  = 8'h0A;
   localparam logic [7:0] CR  = 8'h0D;
   localparam logic [7:0] TAB = 8'h09;
   localparam logic [7:0] VT  = 8'h0B;
   localparam logic [7:0] FF  = 8'h0C;
   localparam logic [7:0] SP  = 8'h20;

   localparam int CSR_STRIDE     = 4;
   localparam int TARGET_BYTES   = 750;
   localparam int BYTES_PER_SET  = 110;
   localparam int HOLD_CYCLES    = 120;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MAX_OUTPUT =
      CSR_ADDR_WIDTH'(CSR_STRIDE * CSR_IDX_MAX_OUTPUT);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNUSED     = CSR_ADDR_WIDTH'(CSR_STRIDE);
   localparam logic [LIMIT_WIDTH-1:0]    LIMIT_TOP       = '1;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_type;

   class chunk_scoreboard;
      localparam int LINE_LIMIT = SIZE_LINE_LIMIT_DEFAULT;
      localparam int CW = COUNT_WIDTH_DEFAULT;
      localparam logic [CW-1:0] COUNT_MAX = '1;

      phase_type        phase;
      sub_phase_type    sub;
      logic [CW-1:0]    remaining;
      bit               minus;
      int unsigned      line_len;
      logic [LIMIT_WIDTH-1:0] emitted;
      logic [LIMIT_WIDTH-1:0] limit;
      result_type       expected_q[$];
      int               errors;
      int               data_seen;
      int               status_seen[5];

      function new();
         limit = MAX_OUTPUT_RESET;
         errors = 0;
         data_seen = 0;
         status_seen = '{0, 0, 0, 0, 0};
         clear_body();
      endfunction

      function void clear_body();
         phase = PH_SIZE;
         sub = SUB_WS;
         remaining = '0;
         minus = 0;
         line_len = 0;
         emitted = '0;
      endfunction

      function void add_digit(int d);
         if (remaining > (COUNT_MAX >> 4)) remaining = COUNT_MAX;
         else remaining = {remaining[CW-5:0], 4'(d)};
      endfunction

      // Handles one size-line byte. ST_DATA here means that no final status was raised.
      function status_type size_line_byte(logic [7:0] c);
         int d;
         logic [CW-1:0] n;
         d = -1;
         if (c >= "0" && c <= "9") d = c - "0";
         else if (c >= "a" && c <= "f") d = c - "a" + 10;
         else if (c >= "A" && c <= "F") d = c - "A" + 10;
         if (c == LF) begin
            n = remaining;
            if (minus && n != 0) n = COUNT_MAX;
            if (line_len >= LINE_LIMIT) return ST_LINE_LONG;
            if (n == 0) return ST_ZERO_CHUNK;
            remaining = n;
            phase = PH_DATA;
            return ST_DATA;
         end
         if (line_len < LINE_LIMIT) line_len++;
         if (phase == PH_SIZE_ZERO) begin
            phase = PH_SIZE;
            if (c == "x" || c == "X") begin
               sub = SUB_DIGITS;
            end else if (d >= 0) begin
               add_digit(d);
               sub = SUB_DIGITS;
            end else begin
               sub = SUB_IGNORE;
            end
            return ST_DATA;
         end
         if (sub == SUB_WS && (c == SP || c == TAB || c == VT || c == FF || c == CR))
            return ST_DATA;
         if (sub == SUB_WS && (c == "+" || c == "-")) begin
            minus = (c == "-");
            sub = SUB_SIGN;
            return ST_DATA;
         end
         if (sub == SUB_WS || sub == SUB_SIGN) begin
            // A lone leading zero may still be the start of a 0x prefix.
            if (c == "0") begin
               phase = PH_SIZE_ZERO;
               sub = SUB_DIGITS;
            end else if (d >= 0) begin
               add_digit(d);
               sub = SUB_DIGITS;
            end else begin
               sub = SUB_IGNORE;
            end
         end else if (sub == SUB_DIGITS) begin
            if (d >= 0) add_digit(d);
            else sub = SUB_IGNORE;
         end
         return ST_DATA;
      endfunction

      function void note_byte(logic [7:0] c, bit eob);
         status_type fin;
         result_type outs[2];
         int k;
         fin = ST_DATA;
         k = 0;
         case (phase)
            PH_SIZE, PH_SIZE_ZERO: fin = size_line_byte(c);
            PH_DATA: begin
               if (emitted >= limit) begin
                  fin = ST_TOO_LARGE;
               end else begin
                  outs[k] = '{out_byte: c, status: ST_DATA, last_of_run: 1'b0};
                  k++;
                  emitted++;
                  remaining--;
                  if (remaining == 0) phase = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (c == LF) begin
                  phase = PH_SIZE;
                  sub = SUB_WS;
                  remaining = '0;
                  minus = 0;
                  line_len = 0;
               end
            end
            default: ;
         endcase
         if (fin == ST_DATA && eob && phase != PH_DONE) fin = ST_EARLY_END;
         if (fin != ST_DATA) begin
            outs[k] = '{out_byte: 8'h00, status: fin, last_of_run: 1'b0};
            k++;
            phase = PH_DONE;
         end
         for (int i = 0; i < k; i++) begin
            if (i == k - 1) outs[i].last_of_run = 1'b1;
            expected_q.push_back(outs[i]);
         end
         if (eob) clear_body();
      endfunction

      function void report_field(string name, logic [7:0] exp, logic [7:0] act);
         if (act !== exp) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
            errors++;
         end
      endfunction

      function void check_result(logic [7:0] b, logic [2:0] st, logic last);
         result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result: out_byte %0h status %0d last_of_run %0b", b, st, last);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         report_field("out_byte", e.out_byte, b);
         report_field("status", 8'(e.status), 8'(st));
         report_field("last_of_run", 8'(e.last_of_run), 8'(last));
         if (e.status == ST_DATA) data_seen++;
         else status_seen[int'(e.status)]++;
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_data_byte;
   logic                      req_end_of_body;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [7:0]                rsp_out_byte;
   logic [2:0]                rsp_status;
   logic                      rsp_last_of_run;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   chunk_scoreboard sb;
   logic [7:0]      body_q[$];
   int              burst_left;
   bit              gaps_on;
   bit              hold_off_pending;
   int              hold_offs;
   int              bytes_accepted;
   int              bodies_done;
   int              settings_used;

   http_chunked_body_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_end_of_body(req_end_of_body),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   // Results are checked before the same edge's input is noted; a result never
   // belongs to an input accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_out_byte, rsp_status, rsp_last_of_run);
         if (req_valid && req_ready) begin
            sb.note_byte(req_data_byte, req_end_of_body);
            bytes_accepted++;
            if (req_end_of_body) bodies_done++;
         end
      end
   end

   initial begin
      rx_mode_type mode;
      int mode_left;
      int tick;
      rsp_ready = 1'b0;
      mode = RX_ALWAYS;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_pending = 0;
            hold_offs++;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 4) != 0);
               default:   rsp_ready <= ((tick % 5) < 2);
            endcase
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $error("no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.expected_q.size());
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input bit eob);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_body <= eob;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_body();
      for (int i = 0; i < body_q.size(); i++) begin
         send_byte(body_q[i], i == body_q.size() - 1);
         if (gaps_on) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               idle_gap($urandom_range(1, 6));
            end else begin
               burst_left--;
            end
         end
      end
   endtask

   // The extra edge lets the monitor note the last accepted byte before the queue is polled.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The bus idles after each write, so back-to-back writes get a fresh setup.
   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_MAX_OUTPUT) sb.limit = data[LIMIT_WIDTH-1:0];
      @(posedge clock);
   endtask

   function automatic void append_str(string s);
      for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
   endfunction

   // Appends one chunk; returns 1 when the chunk leaves the body with a final
   // status or an endless count, so the caller ends the body.
   function automatic bit append_chunk();
      int unsigned kind;
      int unsigned size;
      string digits;
      logic [7:0] ws_set[5];
      ws_set = '{SP, TAB, VT, FF, CR};
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) body_q.push_back(ws_set[$urandom_range(0, 4)]);
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         repeat ($urandom_range(32, 40)) body_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
         body_q.push_back(LF);
         return 1;
      end
      if (kind < 14) begin
         if (kind < 10) begin
            body_q.push_back("-");
            append_str($sformatf("%0h", $urandom_range(1, 4095)));
         end else begin
            append_str($sformatf("%0h%08h", $urandom_range(1, 15), $urandom));
         end
         body_q.push_back(LF);
         return 1;
      end
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      if ($urandom_range(0, 5) == 0) body_q.push_back("+");
      case ($urandom_range(0, 5))
         0: append_str("0x");
         1: append_str("0X");
         2: append_str("0");
         default: ;
      endcase
      digits = $sformatf("%0h", size);
      if ($urandom_range(0, 1)) digits = digits.toupper();
      append_str(digits);
      if ($urandom_range(0, 3) == 0) append_str(";ext=1");
      if ($urandom_range(0, 1)) body_q.push_back(CR);
      body_q.push_back(LF);
      repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) append_str("junk");
      if ($urandom_range(0, 1)) body_q.push_back(CR);
      body_q.push_back(LF);
      return 0;
   endfunction

   function automatic void build_body();
      int unsigned style;
      int unsigned chunks;
      int unsigned cut;
      bit open_ended;
      body_q.delete();
      open_ended = 0;
      style = $urandom_range(0, 99);
      if (style < 8) begin
         repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         chunks = $urandom_range(0, 3);
         for (int i = 0; i < chunks && !open_ended; i++) open_ended = append_chunk();
         if (open_ended) begin
            repeat ($urandom_range(0, 20)) body_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 3) == 0) body_q.push_back(SP);
            append_str("0");
            if ($urandom_range(0, 3) == 0) append_str(";last");
            if ($urandom_range(0, 1)) body_q.push_back(CR);
            body_q.push_back(LF);
            case ($urandom_range(0, 2))
               0: ;
               1: begin
                  body_q.push_back(CR);
                  body_q.push_back(LF);
               end
               default: begin
                  append_str("Trailer: 1");
                  body_q.push_back(LF);
                  body_q.push_back(LF);
               end
            endcase
         end
         // A tenth of the bodies are cut short at a random byte.
         if (style >= 90) begin
            cut = $urandom_range(1, body_q.size());
            while (body_q.size() > cut) void'(body_q.pop_back());
         end
      end
      if (body_q.size() == 0) body_q.push_back(LF);
   endfunction

   initial begin
      logic [LIMIT_WIDTH-1:0] new_limit;
      int set_end;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_end_of_body = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      gaps_on = 0;
      hold_off_pending = 0;
      hold_offs = 0;
      bytes_accepted = 0;
      bodies_done = 0;
      settings_used = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Whitespace, sign and 0X prefix, extreme data bytes, then a zero chunk.
      body_q = '{VT};
      append_str("+0X2");
      body_q.push_back(CR);
      body_q.push_back(LF);
      body_q.push_back(8'h00);
      body_q.push_back(8'hFF);
      body_q.push_back(LF);
      append_str("0");
      body_q.push_back(LF);
      send_body();
      // A minus sign on a nonzero count, then the body ends inside the data.
      body_q.delete();
      append_str("-1");
      body_q.push_back(LF);
      body_q.push_back(8'hA5);
      send_body();
      // The count saturates after nine hex digits.
      body_q.delete();
      append_str("fffffffff");
      body_q.push_back(LF);
      body_q.push_back(8'h5A);
      send_body();
      drain_results();

      for (int p = 0; bytes_accepted < TARGET_BYTES; p++) begin
         case (p % 7)
            0: new_limit = '0;
            1: new_limit = LIMIT_TOP;
            2: new_limit = LIMIT_WIDTH'($urandom_range(1, 40));
            3: new_limit = LIMIT_WIDTH'(1);
            4: new_limit = LIMIT_WIDTH'($urandom_range(41, 400));
            5: new_limit = MAX_OUTPUT_RESET;
            default: new_limit = LIMIT_WIDTH'($urandom_range(0, 2 ** LIMIT_WIDTH - 1));
         endcase
         csr_write(ADDR_MAX_OUTPUT, CSR_DATA_WIDTH'(new_limit));
         // A write past the only register must leave the limit alone.
         if (p % 7 == 3) csr_write(ADDR_UNUSED, CSR_DATA_WIDTH'($urandom_range(0, 1000)));
         settings_used++;
         gaps_on = (p % 3 != 1);
         if (p == 0) hold_off_pending = 1;
         set_end = bytes_accepted + BYTES_PER_SET;
         while (bytes_accepted < set_end) begin
            build_body();
            send_body();
            if ($urandom_range(0, 49) == 0) hold_off_pending = 1;
            if ($urandom_range(0, 24) == 0) drain_results();
         end
         drain_results();
      end

      $display("Covered %0d bytes in %0d bodies under %0d limit settings, %0d long hold-offs.",
               bytes_accepted, bodies_done, settings_used, hold_offs);
      $display("Checked %0d data bytes; zero-chunk %0d, early-end %0d, long-line %0d, too-large %0d.",
               sb.data_seen, sb.status_seen[ST_ZERO_CHUNK], sb.status_seen[ST_EARLY_END],
               sb.status_seen[ST_LINE_LONG], sb.status_seen[ST_TOO_LARGE]);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
src/chd_pkg.sv
src/chd_parse.sv
src/chd_rsp_queue.sv
src/http_chunked_body_decoder.sv
src/chd_checker.sv
verif/tb_http_chunked_body_decoder.sv
